### hdl/prw_pkg.sv
// Shared types and codes for the particle resampling wheel.
package prw_pkg;

  // Item kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_DRAW  = 2'd2
  } kind_e;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // write weight, update max, advance load pointer
    logic start;     // place wheel index, clear accumulator
    logic draw;      // latch fraction, fold index into range
    logic mul;       // capture fraction * max
    logic add;       // add to accumulator, clear step count
    logic step;      // one walk step
    logic out_load;  // copy index to output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic max_zero;
    logic walk_go;
  } sts_t;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FIELD_W = 16;  // weight and fraction field width
  localparam int unsigned CNT_W   = 11;  // particle_count register width
  localparam int unsigned SEL_W   = 10;  // selected_index width
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd100;

endpackage

### hdl/prw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/prw_ctrl.sv
// Controller state machine: input and output handshakes, draw sequencing.
module prw_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [prw_pkg::KIND_W-1:0]   in_kind_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output prw_pkg::cmd_t                cmd_o,
  input  prw_pkg::sts_t                sts_i
);

  prw_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == prw_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      prw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (prw_pkg::kind_e'(in_kind_i))
            prw_pkg::KIND_LOAD:  cmd_o.load = 1'b1;
            prw_pkg::KIND_START: cmd_o.start = 1'b1;
            prw_pkg::KIND_DRAW: begin
              cmd_o.draw = 1'b1;
              state_d    = prw_pkg::ST_MUL;
            end
            default: ;  // unused kind: dropped
          endcase
        end
      end
      prw_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (!sts_i.max_zero) begin
          state_d = prw_pkg::ST_ADD;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = prw_pkg::ST_IDLE;
        end else begin
          state_d = prw_pkg::ST_DONE;
        end
      end
      prw_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = prw_pkg::ST_WALK;
      end
      prw_pkg::ST_WALK: begin
        if (sts_i.walk_go) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = prw_pkg::ST_IDLE;
        end else begin
          state_d = prw_pkg::ST_DONE;
        end
      end
      prw_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = prw_pkg::ST_IDLE;
        end
      end
      default: state_d = prw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/prw_dp.sv
// Datapath: weight store, max tracking, accumulator and wheel walk.
module prw_dp #(
  parameter int unsigned MAX_PARTICLES = 1024,
  parameter int unsigned WEIGHT_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [prw_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic [prw_pkg::FIELD_W-1:0]   weight_i,
  input  logic [prw_pkg::FIELD_W-1:0]   frac_i,
  input  prw_pkg::cmd_t                 cmd_i,
  output prw_pkg::sts_t                 sts_o,
  output logic [prw_pkg::SEL_W-1:0]     sel_o
);

  localparam int unsigned FW      = prw_pkg::FIELD_W;
  localparam int unsigned WB      = WEIGHT_BITS;
  localparam int unsigned EFF_MAX = (MAX_PARTICLES < 2047) ? MAX_PARTICLES : 2047;
  localparam int unsigned IDX_W   = $clog2(EFF_MAX);
  localparam int unsigned NW      = IDX_W + 1;
  localparam int unsigned STEP_W  = NW + 2;
  localparam int unsigned ADDR_W  = $clog2(MAX_PARTICLES);
  localparam int unsigned PTR_W   = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned ACC_W   = WB + 2;
  localparam int unsigned PROD_W  = FW + WB;

  logic [prw_pkg::CNT_W-1:0] count_q;
  logic [PTR_W-1:0]          ptr_q;
  logic [WB-1:0]             max_q;
  logic [ACC_W-1:0]          acc_q, acc_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [FW-1:0]             frac_q;
  logic [PROD_W-1:0]         prod_q;
  logic [STEP_W-1:0]         steps_q;
  logic [prw_pkg::SEL_W-1:0] sel_q;

  logic [NW-1:0]             n;
  logic [STEP_W-1:0]         limit;
  logic [WB+FW-1:0]          w_ext;
  logic [WB-1:0]             w;
  logic                      store_we;
  logic [WB-1:0]             cur;
  logic [FW+NW-1:0]          start_prod;
  logic [NW-1:0]             idx_inc;
  logic [IDX_W-1:0]          idx_next;
  logic [ACC_W:0]            acc_sum;
  logic [IDX_W+prw_pkg::SEL_W-1:0] sel_ext;

  // Effective count: 0 acts as 1, clipped to the store depth or 2047, whichever is smaller.
  always_comb begin
    if (count_q == '0) begin
      n = NW'(1);
    end else if (32'(count_q) > 32'(EFF_MAX)) begin
      n = NW'(EFF_MAX);
    end else begin
      n = NW'(count_q);
    end
  end

  assign limit      = STEP_W'(n) + (STEP_W'(n) << 1);
  assign w_ext      = {{WB{1'b0}}, weight_i};
  assign w          = w_ext[WB-1:0];
  assign store_we   = cmd_i.load && (32'(ptr_q) < 32'(MAX_PARTICLES));
  assign start_prod = frac_i * n;
  assign idx_inc    = {1'b0, idx_q} + NW'(1);
  assign idx_next   = (idx_inc >= n) ? '0 : idx_inc[IDX_W-1:0];
  assign acc_sum    = {1'b0, acc_q} + (ACC_W + 1)'(prod_q[PROD_W-1:FW-1]);
  assign sel_ext    = {{prw_pkg::SEL_W{1'b0}}, idx_q};

  assign sts_o.max_zero = (max_q == '0);
  assign sts_o.walk_go  = (steps_q < limit) && (acc_q > ACC_W'(cur));
  assign sel_o          = sel_q;

  prw_ram #(
    .WIDTH (WB),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (ptr_q[ADDR_W-1:0]),
    .wdata_i (w),
    .raddr_i (ADDR_W'(idx_d)),  // next index: data lines up with idx_q
    .rdata_o (cur)
  );

  always_comb begin
    idx_d = idx_q;
    acc_d = acc_q;
    if (cmd_i.start) begin
      idx_d = start_prod[FW+IDX_W-1:FW];
      acc_d = '0;
    end else if (cmd_i.draw) begin
      if (NW'(idx_q) >= n) begin
        idx_d = '0;
      end
    end else if (cmd_i.add) begin
      acc_d = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    end else if (cmd_i.step) begin
      idx_d = idx_next;
      acc_d = acc_q - ACC_W'(cur);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= prw_pkg::CNT_RESET;
      ptr_q   <= '0;
      max_q   <= '0;
      acc_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        if (ptr_q == '0 || w > max_q) begin
          max_q <= w;
        end
        if (store_we) begin
          ptr_q <= ptr_q + PTR_W'(1);
        end
      end else if (cmd_i.start) begin
        ptr_q <= '0;
      end
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw) begin
      frac_q <= frac_i;
    end
    if (cmd_i.mul) begin
      prod_q <= frac_q * max_q;
    end
    if (cmd_i.add) begin
      steps_q <= '0;
    end else if (cmd_i.step) begin
      steps_q <= steps_q + STEP_W'(1);
    end
    if (cmd_i.out_load) begin
      sel_q <= sel_ext[prw_pkg::SEL_W-1:0];
    end
  end

endmodule

### hdl/particle_resampling_wheel_core.sv
// Top level of the particle resampling wheel: controller plus datapath.
//
//  channel   | direction | transaction             | payload
//  ----------+-----------+-------------------------+---------------------------------
//  s_axis    | in        | tvalid & tready         | tuser: kind; tdata: weight, fraction
//  m_axis    | out       | tvalid & tready         | tdata: selected_index
//  cfg       | in        | cfg_valid_i & cfg_ready_o | cfg_data_i: particle_count
//
// A draw runs through the multiply and add states and then the wheel walk; the
// walk reads one weight per cycle from the store RAM. A draw with a zero maximum
// skips the add and the walk. The result sits in an output register, so the
// next item is taken while it waits. Reset is asynchronous, active low; the
// weight store is not cleared.
module particle_resampling_wheel_core #(
  parameter int unsigned MAX_PARTICLES = 1024,
  parameter int unsigned WEIGHT_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] weight, [31:16] random_fraction
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] selected_index, [15:10] zero
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i      // particle_count
);

  prw_pkg::cmd_t             cmd;
  prw_pkg::sts_t             sts;
  logic [prw_pkg::SEL_W-1:0] sel;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {{(16 - prw_pkg::SEL_W){1'b0}}, sel};

  prw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  prw_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .weight_i   (s_axis_tdata[15:0]),
    .frac_i     (s_axis_tdata[31:16]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sel_o      (sel)
  );

endmodule
